// ===== design/pscsa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pscsa_pkg
// Shared field widths, status codes and word layouts of the size class
// slot allocator.
// ----------------------------------------------------------------------------
package pscsa_pkg;

  localparam int REQ_W        = 20;
  localparam int FCLS_W       = 4;
  localparam int FSLOT_W      = 5;
  localparam int CLS_W        = 4;
  localparam int SLOT_W       = 5;
  localparam int BYTES_W      = 19;
  localparam int STAT_W       = 3;
  localparam int TOTAL_W      = REQ_W + 1;
  localparam int HEADER_BYTES = 4;
  localparam int MIN_BLOCK    = 8;

  typedef enum logic [STAT_W-1:0] {
    ST_ALLOC      = 3'd0,
    ST_FREED      = 3'd1,
    ST_EXHAUSTED  = 3'd2,
    ST_TOO_LARGE  = 3'd3,
    ST_STACK_FULL = 3'd4
  } status_t;

  typedef struct packed {
    logic               kind;
    logic [REQ_W-1:0]   request_bytes;
    logic [FCLS_W-1:0]  free_class;
    logic [FSLOT_W-1:0] free_slot;
  } request_t;

  typedef struct packed {
    status_t            status;
    logic [CLS_W-1:0]   size_class;
    logic [SLOT_W-1:0]  slot;
    logic [BYTES_W-1:0] block_bytes;
    logic               reused;
  } result_t;

endpackage
`default_nettype wire

// ===== design/pow2_size_class_slot_allocator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pow2_size_class_slot_allocator_core
// Power-of-two segregated slot allocator with per-class free stacks.
// ----------------------------------------------------------------------------
// Takes one request word per cycle while the output is not stalled and
// returns one result word per request: the accepting edge registers the
// request, which is then decided against the per-class counters and the free
// stack memory (NUM_CLASSES * SLOTS_PER_CLASS entries, one read or write per
// cycle); the result is registered once the output register can take it.
// A stalled output holds the result word, and once the request register is
// also full the input stalls. An allocate adds a 4-byte header, rounds up to
// a power of two of at least 8 bytes and pops the class's free stack (last
// freed first) or else hands out the next unused slot. A free pushes its
// slot onto the named class's stack; double frees are not detected. Reset
// clears the counters at once; the stack memory needs no clearing.
module pow2_size_class_slot_allocator_core #(
  parameter int NUM_CLASSES     = 16,
  parameter int SLOTS_PER_CLASS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // request_bytes, free_class, free_slot
  input  logic [0:0]  in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // size_class, slot, block_bytes, reused
  output logic [2:0]  out_tuser   // status
);

  localparam int CLASS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  logic                         s1_valid_r;
  pscsa_pkg::request_t          s1_req_r;
  logic                         s2_valid_r;
  pscsa_pkg::result_t           s2_res_r;
  logic                         s2_ready;
  logic                         s1_adv;
  logic [CLASS_W-1:0]           cls_map;
  logic                         too_large;
  pscsa_pkg::result_t           res;
  logic [pscsa_pkg::SLOT_W-1:0] pop_slot;
  logic [pscsa_pkg::SLOT_W-1:0] slot_out;

  assign s2_ready  = !s2_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && s2_ready;
  assign in_tready = !s1_valid_r || s2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_req_r.kind          <= in_tuser[0];
      s1_req_r.request_bytes <= in_tdata[19:0];
      s1_req_r.free_class    <= in_tdata[23:20];
      s1_req_r.free_slot     <= in_tdata[28:24];
    end
    if (s1_adv) begin
      s2_res_r <= res;
    end
  end

  pscsa_class_map #(
    .NUM_CLASSES (NUM_CLASSES),
    .CLASS_W     (CLASS_W)
  ) u_class_map (
    .request_bytes (s1_req_r.request_bytes),
    .cls           (cls_map),
    .too_large     (too_large)
  );

  pscsa_slot_ctl #(
    .NUM_CLASSES     (NUM_CLASSES),
    .SLOTS_PER_CLASS (SLOTS_PER_CLASS),
    .CLASS_W         (CLASS_W)
  ) u_slot_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .issue     (s1_adv),
    .req       (s1_req_r),
    .cls_map   (cls_map),
    .too_large (too_large),
    .res       (res),
    .pop_slot  (pop_slot)
  );

  // popped slot arrives from the stack memory's read register
  assign slot_out   = s2_res_r.reused ? pop_slot : s2_res_r.slot;
  assign out_tvalid = s2_valid_r;
  assign out_tuser  = s2_res_r.status;
  assign out_tdata  = {3'b000, s2_res_r.reused, s2_res_r.block_bytes, slot_out,
                       s2_res_r.size_class};

endmodule
`default_nettype wire

// ===== design/pscsa_class_map.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pscsa_class_map
// Adds the block header to a request and finds the smallest power-of-two
// class that holds it.
// ----------------------------------------------------------------------------
module pscsa_class_map #(
  parameter int NUM_CLASSES = 16,
  parameter int CLASS_W     = 4
) (
  input  logic [pscsa_pkg::REQ_W-1:0] request_bytes,
  output logic [CLASS_W-1:0]          cls,
  output logic                        too_large
);

  localparam int CMP_W = (pscsa_pkg::TOTAL_W > NUM_CLASSES + 3) ?
                         pscsa_pkg::TOTAL_W : NUM_CLASSES + 3;

  logic [CMP_W-1:0]       total;
  logic [NUM_CLASSES-1:0] fits;

  always_comb begin
    total = CMP_W'(request_bytes) + CMP_W'(pscsa_pkg::HEADER_BYTES);
    for (int i = 0; i < NUM_CLASSES; i++) begin
      fits[i] = (CMP_W'(pscsa_pkg::MIN_BLOCK) << i) >= total;
    end
    // fits is monotonic, so the lowest set bit is the class
    cls = '0;
    for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
      if (fits[i]) begin
        cls = CLASS_W'(i);
      end
    end
    too_large = !fits[NUM_CLASSES-1];
  end

endmodule
`default_nettype wire

// ===== design/pscsa_slot_ctl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pscsa_slot_ctl
// Per-class bump counters, free stack depths and the free stack memory;
// decides each request and updates the class state in the same cycle.
// ----------------------------------------------------------------------------
module pscsa_slot_ctl #(
  parameter int NUM_CLASSES     = 16,
  parameter int SLOTS_PER_CLASS = 32,
  parameter int CLASS_W         = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         issue,
  input  pscsa_pkg::request_t          req,
  input  logic [CLASS_W-1:0]           cls_map,
  input  logic                         too_large,
  output pscsa_pkg::result_t           res,
  output logic [pscsa_pkg::SLOT_W-1:0] pop_slot
);

  localparam int CNT_W  = $clog2(SLOTS_PER_CLASS + 1);
  localparam int DEPTH  = NUM_CLASSES * SLOTS_PER_CLASS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CNT_W-1:0]                 bump_count_r [NUM_CLASSES];
  logic [CNT_W-1:0]                 free_top_r   [NUM_CLASSES];
  logic [pscsa_pkg::FSLOT_W-1:0]    free_stack_r [DEPTH];
  logic [pscsa_pkg::SLOT_W-1:0]     pop_slot_r;

  logic [CLASS_W-1:0] cidx;
  logic [CNT_W-1:0]   top_cur;
  logic [CNT_W-1:0]   bump_cur;
  logic [CNT_W-1:0]   top_nxt;
  logic [CNT_W-1:0]   bump_nxt;
  logic [ADDR_W-1:0]  base;
  logic [ADDR_W-1:0]  addr;
  logic               free_bad;
  logic               do_pop;
  logic               do_push;
  logic               do_bump;
  logic [pscsa_pkg::BYTES_W-1:0] bytes;

  always_comb begin
    cidx     = req.kind ? CLASS_W'(req.free_class) : cls_map;
    top_cur  = free_top_r[cidx];
    bump_cur = bump_count_r[cidx];
    free_bad = (32'(req.free_class) >= NUM_CLASSES) ||
               (32'(req.free_slot) >= SLOTS_PER_CLASS);
    base     = ADDR_W'(cidx) * ADDR_W'(SLOTS_PER_CLASS);
    bytes    = pscsa_pkg::BYTES_W'(pscsa_pkg::MIN_BLOCK) << cidx;
    addr     = base + ADDR_W'(top_cur);
    top_nxt  = top_cur;
    bump_nxt = bump_cur + CNT_W'(1);
    do_pop   = 1'b0;
    do_push  = 1'b0;
    do_bump  = 1'b0;
    res      = '0;
    if (!req.kind) begin
      priority if (too_large) begin
        res.status = pscsa_pkg::ST_TOO_LARGE;
      end else if (top_cur != '0) begin
        do_pop           = 1'b1;
        top_nxt          = top_cur - CNT_W'(1);
        addr             = base + ADDR_W'(top_nxt);
        res.status       = pscsa_pkg::ST_ALLOC;
        res.size_class   = pscsa_pkg::CLS_W'(cidx);
        res.block_bytes  = bytes;
        res.reused       = 1'b1;
      end else if (bump_cur < CNT_W'(SLOTS_PER_CLASS)) begin
        do_bump          = 1'b1;
        res.status       = pscsa_pkg::ST_ALLOC;
        res.size_class   = pscsa_pkg::CLS_W'(cidx);
        res.slot         = pscsa_pkg::SLOT_W'(bump_cur);
        res.block_bytes  = bytes;
      end else begin
        res.status       = pscsa_pkg::ST_EXHAUSTED;
        res.size_class   = pscsa_pkg::CLS_W'(cidx);
      end
    end else begin
      res.size_class = req.free_class;
      res.slot       = req.free_slot;
      priority if (free_bad) begin
        res.status = pscsa_pkg::ST_TOO_LARGE;
      end else if (top_cur >= CNT_W'(SLOTS_PER_CLASS)) begin
        res.status = pscsa_pkg::ST_STACK_FULL;
      end else begin
        do_push         = 1'b1;
        top_nxt         = top_cur + CNT_W'(1);
        res.status      = pscsa_pkg::ST_FREED;
        res.block_bytes = bytes;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        bump_count_r[i] <= '0;
        free_top_r[i]   <= '0;
      end
    end else if (issue) begin
      if (do_pop || do_push) begin
        free_top_r[cidx] <= top_nxt;
      end
      if (do_bump) begin
        bump_count_r[cidx] <= bump_nxt;
      end
    end
  end

  // free stack memory, registered read
  always_ff @(posedge clk) begin
    if (issue && do_push) begin
      free_stack_r[addr] <= req.free_slot;
    end
    if (issue && do_pop) begin
      pop_slot_r <= free_stack_r[addr];
    end
  end

  assign pop_slot = pop_slot_r;

endmodule
`default_nettype wire
